// ----- hdl/grid_waypoint_shortest_path_macros.svh -----
// ----------------------------------------------------------------------------
// Grid waypoint shortest path: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef GRID_WAYPOINT_SHORTEST_PATH_MACROS_SVH
`define GRID_WAYPOINT_SHORTEST_PATH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GWSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GWSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gwsp_pkg.sv -----
// ----------------------------------------------------------------------------
// gwsp_pkg
// Types, constants and helper functions shared by the grid path search.
// ----------------------------------------------------------------------------
`default_nettype none

package gwsp_pkg;

  localparam int CELL_W     = 6;
  localparam int NUM_CELLS  = 64;
  localparam int ROW_STRIDE = 8;
  localparam int DIM_W      = 4;
  localparam int COORD_W    = 3;
  localparam int DIST_W     = 6;
  localparam int COST_W     = 7;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_MAX_ROWS = 8;
  localparam int DEF_MAX_COLS = 8;

  localparam logic [NUM_CELLS-1:0] COL0_BITS = 64'h0101_0101_0101_0101;
  localparam logic [NUM_CELLS-1:0] COL7_BITS = 64'h8080_8080_8080_8080;

  localparam logic [DIM_W-1:0]     RST_GRID_ROWS = 4'd3;
  localparam logic [DIM_W-1:0]     RST_GRID_COLS = 4'd5;
  localparam logic [NUM_CELLS-1:0] RST_WALL_MASK = 64'd1049872;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WALL = 2'd2;

  // Control from the sequencer to the wavefront datapath.
  typedef struct packed {
    logic              load;
    logic              expand;
    logic [CELL_W-1:0] src_cell;
    logic [CELL_W-1:0] dst_cell;
  } gwsp_ctl_t;

  // Status back from the wavefront datapath.
  typedef struct packed {
    logic              hit;
    logic              done;
    logic [DIST_W-1:0] steps;
  } gwsp_stat_t;

  // Mask of the cells inside a grid of the given (already clamped) size.
  function automatic logic [NUM_CELLS-1:0] grid_cells(input logic [DIM_W-1:0] rows,
                                                      input logic [DIM_W-1:0] cols);
    logic [NUM_CELLS-1:0] m;
    logic [CELL_W-1:0]    idx;
    m = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      idx  = CELL_W'(i);
      m[i] = ({1'b0, idx[5:3]} < rows) && ({1'b0, idx[2:0]} < cols);
    end
    return m;
  endfunction

  // 4-neighbour dilation of a cell bitmap, no wrap across row edges.
  function automatic logic [NUM_CELLS-1:0] neighbours(input logic [NUM_CELLS-1:0] f);
    return (f >> ROW_STRIDE) | (f << ROW_STRIDE) |
           ((f >> 1) & ~COL7_BITS) | ((f << 1) & ~COL0_BITS);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/grid_waypoint_shortest_path.sv -----
// ----------------------------------------------------------------------------
// grid_waypoint_shortest_path
// Fewest 4-neighbour steps from a start cell through a waypoint to a goal.
// ----------------------------------------------------------------------------
// An item is accepted at a rising edge with start high and busy low. The block
// searches the start-to-waypoint leg and then the waypoint-to-goal leg, each by
// a bitmap wavefront that advances one distance step per clock, and presents
// one result for exactly one cycle with out_valid high. The receiver cannot
// stall: the result must be captured in that cycle. A search leg ends when its
// target is reached or its wave dies out; an out-of-grid coordinate skips both
// searches and gives an unreachable result.
// busy drops in the cycle the result is shown, so the next item can be taken
// then. Configuration writes are always ready and must only be issued while
// busy is low.
`default_nettype none

module grid_waypoint_shortest_path
  import gwsp_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Command channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [COORD_W-1:0]   in_start_row,
  input  wire logic [COORD_W-1:0]   in_start_col,
  input  wire logic [COORD_W-1:0]   in_via_row,
  input  wire logic [COORD_W-1:0]   in_via_col,
  input  wire logic [COORD_W-1:0]   in_goal_row,
  input  wire logic [COORD_W-1:0]   in_goal_col,
  // Result channel
  output logic                      out_valid,
  output logic [COST_W-1:0]         out_total_cost,
  output logic                      out_reachable,
  // Configuration channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [NUM_CELLS-1:0] cfg_wdata
);

  // Microcode: each step names a datapath operation, a jump condition and
  // the targets taken when the condition is true or false.
  localparam int STEP_W = 4;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD1, OP_EXPAND, OP_SAVE1, OP_LOAD2, OP_EMIT_OK, OP_EMIT_FAIL
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_START, C_OUTGRID, C_DONE, C_HIT
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [STEP_W-1:0] tgt_true;
    logic [STEP_W-1:0] tgt_false;
  } ucode_t;

  localparam logic [STEP_W-1:0] S_WAIT  = 4'd0;
  localparam logic [STEP_W-1:0] S_LEG1  = 4'd1;
  localparam logic [STEP_W-1:0] S_SRCH1 = 4'd2;
  localparam logic [STEP_W-1:0] S_CHK1  = 4'd3;
  localparam logic [STEP_W-1:0] S_LEG2  = 4'd4;
  localparam logic [STEP_W-1:0] S_SRCH2 = 4'd5;
  localparam logic [STEP_W-1:0] S_CHK2  = 4'd6;
  localparam logic [STEP_W-1:0] S_PASS  = 4'd7;
  localparam logic [STEP_W-1:0] S_FAIL  = 4'd8;

  // The control store. The search steps jump back to themselves until the
  // wavefront reports that the leg has ended.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      S_WAIT:  w = '{OP_NONE,      C_START,   S_LEG1,  S_WAIT};
      S_LEG1:  w = '{OP_LOAD1,     C_OUTGRID, S_FAIL,  S_SRCH1};
      S_SRCH1: w = '{OP_EXPAND,    C_DONE,    S_CHK1,  S_SRCH1};
      S_CHK1:  w = '{OP_SAVE1,     C_HIT,     S_LEG2,  S_FAIL};
      S_LEG2:  w = '{OP_LOAD2,     C_ALWAYS,  S_SRCH2, S_SRCH2};
      S_SRCH2: w = '{OP_EXPAND,    C_DONE,    S_CHK2,  S_SRCH2};
      S_CHK2:  w = '{OP_NONE,      C_HIT,     S_PASS,  S_FAIL};
      S_PASS:  w = '{OP_EMIT_OK,   C_ALWAYS,  S_WAIT,  S_WAIT};
      S_FAIL:  w = '{OP_EMIT_FAIL, C_ALWAYS,  S_WAIT,  S_WAIT};
      default: w = '{OP_NONE,      C_ALWAYS,  S_WAIT,  S_WAIT};
    endcase
    return w;
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0]     grid_rows_r;
  logic [DIM_W-1:0]     grid_cols_r;
  logic [NUM_CELLS-1:0] wall_mask_r;

  // Sequencer and captured item.
  logic [STEP_W-1:0]    pc_r, pc_nxt;
  logic [CELL_W-1:0]    s_cell_r, v_cell_r, g_cell_r;
  logic [NUM_CELLS-1:0] open_r, open_nxt;
  logic [DIST_W-1:0]    first_cost_r, first_cost_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COST_W-1:0]    out_cost_r, out_cost_nxt;
  logic                 out_reach_r, out_reach_nxt;

  ucode_t               uw;
  logic                 cond_true;
  logic                 accept;
  logic [DIM_W-1:0]     rows_eff;
  logic [DIM_W-1:0]     cols_eff;
  logic                 s_in, v_in, g_in;
  gwsp_ctl_t            wave_ctl;
  gwsp_stat_t           wave_stat;

  assign busy      = (pc_r != S_WAIT);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Rows or columns beyond the build-time maximum count as that maximum.
  assign rows_eff = (grid_rows_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows_r;
  assign cols_eff = (grid_cols_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols_r;

  assign s_in = ({1'b0, s_cell_r[5:3]} < rows_eff) && ({1'b0, s_cell_r[2:0]} < cols_eff);
  assign v_in = ({1'b0, v_cell_r[5:3]} < rows_eff) && ({1'b0, v_cell_r[2:0]} < cols_eff);
  assign g_in = ({1'b0, g_cell_r[5:3]} < rows_eff) && ({1'b0, g_cell_r[2:0]} < cols_eff);

  assign uw = ucode_rom(pc_r);

  always_comb begin
    case (uw.cond)
      C_ALWAYS:  cond_true = 1'b1;
      C_START:   cond_true = start;
      C_OUTGRID: cond_true = !(s_in && v_in && g_in);
      C_DONE:    cond_true = wave_stat.done;
      C_HIT:     cond_true = wave_stat.hit;
      default:   cond_true = 1'b1;
    endcase
  end

  // Datapath operations decoded from the current control word.
  always_comb begin
    pc_nxt            = cond_true ? uw.tgt_true : uw.tgt_false;
    open_nxt          = open_r;
    first_cost_nxt    = first_cost_r;
    out_valid_nxt     = 1'b0;
    out_cost_nxt      = out_cost_r;
    out_reach_nxt     = out_reach_r;
    wave_ctl.load     = 1'b0;
    wave_ctl.expand   = 1'b0;
    wave_ctl.src_cell = s_cell_r;
    wave_ctl.dst_cell = v_cell_r;
    case (uw.op)
      OP_NONE: begin
      end
      OP_LOAD1: begin
        // The open map is fixed for the whole item: in-grid cells minus walls.
        open_nxt      = grid_cells(rows_eff, cols_eff) & ~wall_mask_r;
        wave_ctl.load = 1'b1;
      end
      OP_EXPAND: begin
        wave_ctl.expand = 1'b1;
      end
      OP_SAVE1: begin
        first_cost_nxt = wave_stat.steps;
      end
      OP_LOAD2: begin
        wave_ctl.load     = 1'b1;
        wave_ctl.src_cell = v_cell_r;
        wave_ctl.dst_cell = g_cell_r;
      end
      OP_EMIT_OK: begin
        out_valid_nxt = 1'b1;
        out_cost_nxt  = COST_W'(first_cost_r) + COST_W'(wave_stat.steps);
        out_reach_nxt = 1'b1;
      end
      OP_EMIT_FAIL: begin
        out_valid_nxt = 1'b1;
        out_cost_nxt  = '0;
        out_reach_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and registered result outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_cost_r   <= out_cost_nxt;
    out_reach_r  <= out_reach_nxt;
    open_r       <= open_nxt;
    first_cost_r <= first_cost_nxt;
  end

  // Coordinates are packed as row * 8 + column on the accepting transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_cell_r <= {in_start_row, in_start_col};
      v_cell_r <= {in_via_row, in_via_col};
      g_cell_r <= {in_goal_row, in_goal_col};
    end
  end

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= RST_GRID_ROWS;
      grid_cols_r <= RST_GRID_COLS;
      wall_mask_r <= RST_WALL_MASK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_ROWS: grid_rows_r <= cfg_wdata[DIM_W-1:0];
        CFG_IDX_COLS: grid_cols_r <= cfg_wdata[DIM_W-1:0];
        CFG_IDX_WALL: wall_mask_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  gwsp_wave u_wave (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (wave_ctl),
    .open_cells (open_r),
    .stat       (wave_stat)
  );

  assign out_valid      = out_valid_r;
  assign out_total_cost = out_cost_r;
  assign out_reachable  = out_reach_r;

endmodule

`default_nettype wire

// ----- hdl/gwsp_wave.sv -----
// ----------------------------------------------------------------------------
// gwsp_wave
// Bitmap wavefront datapath: one distance step per expand cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gwsp_wave
  import gwsp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire gwsp_ctl_t            ctl,
  input  wire logic [NUM_CELLS-1:0] open_cells,
  output gwsp_stat_t                stat
);

  logic [NUM_CELLS-1:0] reached_r, reached_nxt;
  logic [NUM_CELLS-1:0] frontier_r, frontier_nxt;
  logic [CELL_W-1:0]    dst_cell_r, dst_cell_nxt;
  logic [DIST_W-1:0]    dist_r, dist_nxt;
  logic [NUM_CELLS-1:0] grow;
  logic                 hit;
  logic                 done;

  assign hit  = frontier_r[dst_cell_r];
  assign grow = neighbours(frontier_r) & open_cells & ~reached_r;
  // A leg ends when the target is in the frontier, the wave dies out, or the
  // distance counter is exhausted.
  assign done = hit || (grow == '0) || (&dist_r);

  always_comb begin
    reached_nxt  = reached_r;
    frontier_nxt = frontier_r;
    dst_cell_nxt = dst_cell_r;
    dist_nxt     = dist_r;
    if (ctl.load) begin
      reached_nxt  = NUM_CELLS'(1) << ctl.src_cell;
      frontier_nxt = NUM_CELLS'(1) << ctl.src_cell;
      dst_cell_nxt = ctl.dst_cell;
      dist_nxt     = '0;
    end else if (ctl.expand && !done) begin
      reached_nxt  = reached_r | grow;
      frontier_nxt = grow;
      dist_nxt     = dist_r + DIST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r  <= '0;
      frontier_r <= '0;
      dist_r     <= '0;
    end else begin
      reached_r  <= reached_nxt;
      frontier_r <= frontier_nxt;
      dist_r     <= dist_nxt;
    end
    dst_cell_r <= dst_cell_nxt;
  end

  assign stat.hit   = hit;
  assign stat.done  = done;
  assign stat.steps = dist_r;

endmodule

`default_nettype wire

// ----- hdl/gwsp_checker.sv -----
// ----------------------------------------------------------------------------
// gwsp_checker
// Port-level checks on the command and result channels, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_waypoint_shortest_path_macros.svh"

module gwsp_checker
  import gwsp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [COST_W-1:0] out_total_cost,
  input wire logic              out_reachable
);

  `GWSP_ASSERT_IMP(a_fail_cost_zero, clk, rst_n, out_valid && !out_reachable, out_total_cost == '0, "unreachable result carries a nonzero cost")
  `GWSP_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted command did not raise busy")
  `GWSP_ASSERT_IMP(a_result_after_busy, clk, rst_n, out_valid, $past(busy), "result strobe without a command in progress")
  `GWSP_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe lasted more than one cycle")

endmodule

bind grid_waypoint_shortest_path gwsp_checker u_gwsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_total_cost (out_total_cost),
  .out_reachable  (out_reachable)
);

`default_nettype wire

// ----- sim/grid_waypoint_shortest_path_test.sv -----
// ----------------------------------------------------------------------------
// grid_waypoint_shortest_path_test
// Self-checking bench for the grid path search through a waypoint. A directed
// table covers grid extremes, walls on leg endpoints and out-of-grid cells.
// Random grids and routes follow. Each result is checked against a typed value
// from the table or a bitmap wavefront model kept inside the bench.
// ----------------------------------------------------------------------------
module grid_waypoint_shortest_path_test
  import gwsp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The block ignores writes to the one spare register index.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  // Marks a table row whose result comes from the bench model.
  localparam int NOT_TYPED = -1;

  localparam int CYCLE_LIMIT     = 1_000_000;
  // Longest route is two 63-step legs plus the fixed pipeline overhead.
  localparam int END_SLACK       = 140;
  localparam int MAX_GAP         = 17;
  localparam int RANDOM_PHASES   = 13;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int PLAN_ROWS       = 31;

  // Serpentine maze: rows 1, 3 and 5 are walls with one gap at alternating
  // ends, row 7 is solid. Forces the longest legs the grid can produce.
  localparam logic [NUM_CELLS-1:0] SNAKE_WALLS = 64'hFF00_7F00_FE00_7F00;

  typedef struct packed {
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] via_row;
    logic [COORD_W-1:0] via_col;
    logic [COORD_W-1:0] goal_row;
    logic [COORD_W-1:0] goal_col;
  } route_req_t;

  typedef struct packed {
    logic [COST_W-1:0] total_cost;
    logic              reachable;
  } route_result_t;

  typedef enum logic {PLAN_ROUTE, PLAN_GRID} plan_kind_t;

  typedef struct packed {
    plan_kind_t           kind;
    route_req_t           req;
    logic [DIM_W-1:0]     rows;
    logic [DIM_W-1:0]     cols;
    logic [NUM_CELLS-1:0] walls;
    logic                 typed;
    route_result_t        want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [COORD_W-1:0] in_start_row, in_start_col;
  logic [COORD_W-1:0] in_via_row, in_via_col;
  logic [COORD_W-1:0] in_goal_row, in_goal_col;
  logic out_valid;
  logic [COST_W-1:0] out_total_cost;
  logic out_reachable;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NUM_CELLS-1:0] cfg_wdata;

  // Bench copy of the configuration registers.
  logic [DIM_W-1:0]     rows_reg;
  logic [DIM_W-1:0]     cols_reg;
  logic [NUM_CELLS-1:0] walls_reg;

  // Results still owed by the block, oldest first.
  route_result_t route_expect_q[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;

  plan_row_t directed_plan [PLAN_ROWS];

  grid_waypoint_shortest_path u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_start_row  (in_start_row),
    .in_start_col  (in_start_col),
    .in_via_row    (in_via_row),
    .in_via_col    (in_via_col),
    .in_goal_row   (in_goal_row),
    .in_goal_col   (in_goal_col),
    .out_valid     (out_valid),
    .out_total_cost(out_total_cost),
    .out_reachable (out_reachable),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Route model
  // --------------------------------------------------------------------------

  // Dimensions beyond the physical grid count as the full grid.
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  // Cells inside the configured grid, one bit per cell at row*8+col.
  function automatic logic [NUM_CELLS-1:0] cells_in_grid();
    logic [NUM_CELLS-1:0] m;
    int unsigned          nr, nc;
    m  = '0;
    nr = clamp_dim(rows_reg, DEF_MAX_ROWS);
    nc = clamp_dim(cols_reg, DEF_MAX_COLS);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        m[r*ROW_STRIDE + c] = 1'b1;
    return m;
  endfunction

  // Grows a wave from src one distance step per pass until it covers dst or
  // dies out. The source is seeded even if it is a wall; the wall bits only
  // keep the wave from entering cells, so a walled target is never reached
  // unless it is the source itself.
  function automatic logic leg_steps(input int unsigned src, input int unsigned dst,
                                     input logic [NUM_CELLS-1:0] open_cells,
                                     output logic [DIST_W-1:0] steps);
    logic [NUM_CELLS-1:0] seen, wave, grow;
    steps = '0;
    seen  = '0;
    seen[src] = 1'b1;
    wave  = seen;
    for (int d = 0; d < NUM_CELLS; d++) begin
      if (wave[dst]) begin
        steps = DIST_W'(d);
        return 1'b1;
      end
      // Shifts by one column must not wrap into the neighboring row.
      grow = (wave >> ROW_STRIDE) | (wave << ROW_STRIDE) |
             ((wave >> 1) & ~COL7_BITS) | ((wave << 1) & ~COL0_BITS);
      grow = grow & open_cells & ~seen;
      if (grow == '0) return 1'b0;
      seen = seen | grow;
      wave = grow;
    end
    return 1'b0;
  endfunction

  function automatic route_result_t predict_route(input route_req_t req);
    route_result_t        res;
    logic [NUM_CELLS-1:0] cells, open_cells;
    logic [DIST_W-1:0]    first_leg, second_leg;
    int unsigned          s, v, g;
    logic                 ok;
    res        = '0;
    cells      = cells_in_grid();
    open_cells = cells & ~walls_reg;
    s = req.start_row * ROW_STRIDE + req.start_col;
    v = req.via_row * ROW_STRIDE + req.via_col;
    g = req.goal_row * ROW_STRIDE + req.goal_col;
    // Any coordinate outside the grid makes the whole route unreachable.
    ok = cells[s] && cells[v] && cells[g];
    if (ok) ok = leg_steps(s, v, open_cells, first_leg);
    if (ok) ok = leg_steps(v, g, open_cells, second_leg);
    if (ok) begin
      res.total_cost = {1'b0, first_leg} + {1'b0, second_leg};
      res.reachable  = 1'b1;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic plan_row_t route_row(input int sr, input int sc, input int vr,
                                          input int vc, input int gr, input int gc,
                                          input int cost = NOT_TYPED, input int reach = 0);
    plan_row_t p;
    p      = '0;
    p.kind = PLAN_ROUTE;
    p.req  = '{COORD_W'(sr), COORD_W'(sc), COORD_W'(vr), COORD_W'(vc),
               COORD_W'(gr), COORD_W'(gc)};
    p.typed = (cost != NOT_TYPED);
    if (p.typed) p.want = '{COST_W'(cost), 1'(reach)};
    return p;
  endfunction

  function automatic plan_row_t grid_row(input int rows, input int cols,
                                         input logic [NUM_CELLS-1:0] walls);
    plan_row_t p;
    p       = '0;
    p.kind  = PLAN_GRID;
    p.rows  = DIM_W'(rows);
    p.cols  = DIM_W'(cols);
    p.walls = walls;
    return p;
  endfunction

  // Picks a cell inside an nr x nc grid, retrying a few times to land on an
  // open one so that most legs have somewhere to go.
  function automatic void pick_cell(input int unsigned nr, input int unsigned nc,
                                    input logic [NUM_CELLS-1:0] open_cells,
                                    output logic [COORD_W-1:0] row,
                                    output logic [COORD_W-1:0] col);
    for (int t = 0; t < 4; t++) begin
      row = COORD_W'($urandom_range(0, nr - 1));
      col = COORD_W'($urandom_range(0, nc - 1));
      if (open_cells[row*ROW_STRIDE + col]) return;
    end
  endfunction

  function automatic route_req_t random_route();
    route_req_t           r;
    logic [NUM_CELLS-1:0] open_cells;
    int unsigned          nr, nc;
    nr = clamp_dim(rows_reg, DEF_MAX_ROWS);
    nc = clamp_dim(cols_reg, DEF_MAX_COLS);
    open_cells = cells_in_grid() & ~walls_reg;
    if (nr == 0 || nc == 0 || $urandom_range(0, 9) == 0) begin
      // Unconstrained coordinates, which may fall off the grid.
      r = '{COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7)),
            COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7)),
            COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7))};
    end else begin
      // The start may sit on a wall; the block ignores a wall under a source.
      r.start_row = COORD_W'($urandom_range(0, nr - 1));
      r.start_col = COORD_W'($urandom_range(0, nc - 1));
      pick_cell(nr, nc, open_cells, r.via_row, r.via_col);
      pick_cell(nr, nc, open_cells, r.goal_row, r.goal_col);
    end
    return r;
  endfunction

  function automatic logic [NUM_CELLS-1:0] random_walls();
    logic [NUM_CELLS-1:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return '0;
      1: return a & b;
      2: return a & b & c;
      3: return a | b;
      default: return SNAKE_WALLS ^ (a & b & c);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(0, 7))
      0: return DIM_W'($urandom_range(9, 15));
      1: return DIM_W'($urandom_range(0, 1));
      2, 3: return DIM_W'(8);
      default: return DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  // One transfer on the configuration channel. cfg_valid is left high so a
  // following write with no gap goes out without a dropped cycle; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NUM_CELLS-1:0] data);
    int unsigned gap;
    gap = $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_IDX_ROWS: rows_reg  = data[DIM_W-1:0];
      CFG_IDX_COLS: cols_reg  = data[DIM_W-1:0];
      CFG_IDX_WALL: walls_reg = data;
      default: ;
    endcase
  endtask

  // Reconfigures the grid once the block has delivered every result. Only the
  // low bits of the size words count, so the rest carry random data.
  task automatic set_grid(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                          input logic [NUM_CELLS-1:0] walls, input logic poke_spare);
    logic [NUM_CELLS-1:0] word;
    start <= 1'b0;
    while (route_expect_q.size() != 0) @(posedge clk);
    if (poke_spare) write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
    word = {$urandom, $urandom};
    word[DIM_W-1:0] = rows;
    write_reg(CFG_IDX_ROWS, word);
    word = {$urandom, $urandom};
    word[DIM_W-1:0] = cols;
    write_reg(CFG_IDX_COLS, word);
    write_reg(CFG_IDX_WALL, walls);
    cfg_valid <= 1'b0;
  endtask

  // Offers one route after an idle gap. start is only lowered when a gap is
  // drawn, so back-to-back items keep it high across the accepting edge.
  task automatic send_route(input route_req_t req, input logic typed,
                            input route_result_t typed_want, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_start_row <= req.start_row;
    in_start_col <= req.start_col;
    in_via_row   <= req.via_row;
    in_via_col   <= req.via_col;
    in_goal_row  <= req.goal_row;
    in_goal_col  <= req.goal_col;
    do @(posedge clk); while (busy !== 1'b0);
    route_expect_q.push_back(typed ? typed_want : predict_route(req));
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic note_mismatch(input string field, input logic [COST_W-1:0] want,
                               input logic [COST_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
  endtask

  // Outputs are sampled at the edge that ends the strobe cycle, before the
  // block's own updates at that edge take effect.
  always @(posedge clk) begin : result_check
    route_result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (route_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result, total_cost %0d reachable %0d",
                   $realtime, out_total_cost, out_reachable);
      end else begin
        want = route_expect_q.pop_front();
        if (out_total_cost !== want.total_cost)
          note_mismatch("total_cost", want.total_cost, out_total_cost);
        if (out_reachable !== want.reachable)
          note_mismatch("reachable", COST_W'(want.reachable), COST_W'(out_reachable));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin : main_seq
    route_req_t  req;
    int unsigned gap;
    logic        burst;

    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_start_row <= '0;
    in_start_col <= '0;
    in_via_row   <= '0;
    in_via_col   <= '0;
    in_goal_row  <= '0;
    in_goal_col  <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_IDX_ROWS;
    cfg_wdata    <= '0;
    rows_reg  = RST_GRID_ROWS;
    cols_reg  = RST_GRID_COLS;
    walls_reg = RST_WALL_MASK;

    // Directed plan. The reset grid is 3 rows by 5 columns with walls at
    // (0,4), (1,0), (1,2) and (2,4). Rows with a typed result can be checked
    // by eye; the others rely on the model.
    directed_plan = '{
      route_row(0, 0, 0, 0, 0, 0, 0, 1),    // both legs of zero length
      route_row(0, 0, 0, 1, 0, 0, 2, 1),    // one step out and back
      route_row(7, 7, 7, 7, 7, 7, 0, 0),    // every coordinate off the grid
      route_row(0, 0, 0, 5, 0, 0, 0, 0),    // waypoint column just past the edge
      route_row(0, 0, 0, 0, 3, 0, 0, 0),    // goal row just past the edge
      route_row(0, 0, 1, 0, 0, 0, 0, 0),    // waypoint is a wall
      route_row(1, 0, 0, 0, 0, 1, 2, 1),    // start on a wall still departs
      route_row(1, 2, 1, 2, 1, 2, 0, 1),    // walled cell used as its own target
      route_row(0, 0, 2, 3, 0, 3),
      route_row(2, 0, 0, 4, 2, 0, 0, 0),    // waypoint on the corner wall
      route_row(0, 4, 2, 0, 2, 3),
      grid_row(8, 8, '0),
      route_row(0, 0, 7, 7, 0, 0, 28, 1),   // corner to corner and back
      route_row(7, 0, 0, 7, 7, 7),
      grid_row(8, 8, SNAKE_WALLS),
      route_row(0, 0, 6, 7, 0, 0),
      route_row(6, 0, 0, 7, 6, 0),
      grid_row(15, 15, '1),                 // oversize dims clamp, all walls
      route_row(3, 3, 3, 3, 3, 3, 0, 1),
      route_row(0, 0, 0, 1, 0, 0, 0, 0),
      route_row(7, 7, 7, 7, 7, 7, 0, 1),
      grid_row(0, 8, '0),                   // no rows means no cells at all
      route_row(0, 0, 0, 0, 0, 0, 0, 0),
      grid_row(1, 1, '0),
      route_row(0, 0, 0, 0, 0, 0, 0, 1),
      route_row(0, 1, 0, 0, 0, 0, 0, 0),
      grid_row(8, 1, '0),
      route_row(0, 0, 7, 0, 0, 0, 14, 1),
      grid_row(1, 8, 64'h10),               // single row cut by one wall
      route_row(0, 0, 0, 7, 0, 0, 0, 0),
      route_row(0, 7, 0, 5, 0, 7)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == PLAN_GRID) begin
        set_grid(directed_plan[i].rows, directed_plan[i].cols, directed_plan[i].walls, 1'b1);
      end else begin
        gap = $urandom_range(0, MAX_GAP);
        send_route(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want, gap);
      end
    end

    // Random phases, each on a fresh grid. About one phase in four runs
    // back to back so the accept edge also lands right on the result cycle.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_grid(random_dim(), random_dim(), random_walls(), 1'b0);
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        req = random_route();
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        send_route(req, 1'b0, '0, gap);
      end
    end

    start <= 1'b0;
    while (route_expect_q.size() != 0) @(posedge clk);
    repeat (END_SLACK) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/gwsp_pkg.sv
hdl/gwsp_wave.sv
hdl/grid_waypoint_shortest_path.sv
hdl/gwsp_checker.sv
sim/grid_waypoint_shortest_path_test.sv
